/* rtl/drive_command_frame_encoder_defines.svh */
// Assertion macros shared by the drive command frame encoder RTL.
// No dependencies; the files that assert include this header.
`ifndef DRIVE_COMMAND_FRAME_ENCODER_DEFINES_SVH
`define DRIVE_COMMAND_FRAME_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

`define DCFE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dcfe assertion failed");

`define DCFE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcfe assertion failed");

`else

`define DCFE_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define DCFE_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/dcfe_pkg.sv */
// Types, constants and helper functions for the drive command frame encoder.
// No dependencies.
package dcfe_pkg;

   typedef enum logic [3:0] {
      POS_SYNC,
      POS_ID,
      POS_LEFT_LO,
      POS_LEFT_HI,
      POS_RIGHT_LO,
      POS_RIGHT_HI,
      POS_CTRL,
      POS_CRC_LO,
      POS_CRC_HI
   } byte_pos_type;

   typedef struct packed {
      logic [15:0] left_mag;
      logic [15:0] right_mag;
      logic [7:0]  ctrl;
   } frame_fields_type;

   localparam logic [7:0]  SyncByte  = 8'hFF;
   localparam logic [7:0]  IdByte    = 8'h07;
   localparam logic [15:0] CrcSeed   = 16'hFFFF;
   localparam logic [15:0] CrcPoly   = 16'hA001;
   localparam logic [15:0] MagNegMax = 16'h8000;
   localparam logic [15:0] MagSat    = 16'h7FFF;
   localparam logic [3:0]  CtrlLow   = 4'b1000;

   // Reflected CRC-16, one byte.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   // Magnitude of a two's complement order, most negative code saturated.
   function automatic logic [15:0] magnitude(input logic [15:0] v);
      logic [15:0] m;
      if (v == MagNegMax) begin
         m = MagSat;
      end else if (v[15]) begin
         m = 16'(~v + 16'd1);
      end else begin
         m = v;
      end
      return m;
   endfunction

endpackage

/* rtl/dcfe_input_stage.sv */
// Input holding register: takes one command item and stores its frame fields.
// Depends on dcfe_pkg.
module dcfe_input_stage
   import dcfe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [15:0]      req_left_speed_order,
   input  logic signed [15:0]      req_right_speed_order,
   input  logic                    req_speed_control,
   input  logic                    load_ready,
   output logic                    hold_valid,
   output frame_fields_type        hold_frame
);

   logic             hold_valid_ff, hold_valid_in;
   frame_fields_type hold_frame_ff, hold_frame_in;
   logic             take;

   assign req_stall = hold_valid_ff && !load_ready;
   assign take      = req_valid && !req_stall;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_frame_in = hold_frame_ff;
      if (take) begin
         hold_valid_in           = 1'b1;
         hold_frame_in.left_mag  = magnitude(req_left_speed_order);
         hold_frame_in.right_mag = magnitude(req_right_speed_order);
         hold_frame_in.ctrl      = {req_speed_control, ~req_left_speed_order[15],
                                    req_speed_control, ~req_right_speed_order[15], CtrlLow};
      end else if (load_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_frame_ff <= hold_frame_in;
   end

   assign hold_valid = hold_valid_ff;
   assign hold_frame = hold_frame_ff;

endmodule

/* rtl/dcfe_serializer.sv */
// Byte serializer: emits the nine frame bytes and folds bytes 1..6 into the CRC.
// Depends on dcfe_pkg and drive_command_frame_encoder_defines.svh.
`include "drive_command_frame_encoder_defines.svh"

module dcfe_serializer
   import dcfe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load_valid,
   input  frame_fields_type load_frame,
   output logic             load_ready,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_last_byte
);

   logic             busy_ff, busy_in;
   byte_pos_type     pos_ff, pos_in;
   frame_fields_type frame_ff, frame_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       cur_byte;
   logic             out_take, at_last, load;

   assign at_last    = (pos_ff == POS_CRC_HI);
   assign out_take   = busy_ff && !rsp_stall;
   assign load_ready = !busy_ff || (out_take && at_last);
   assign load       = load_valid && load_ready;

   always_comb begin
      unique case (pos_ff)
         POS_SYNC:     cur_byte = SyncByte;
         POS_ID:       cur_byte = IdByte;
         POS_LEFT_LO:  cur_byte = frame_ff.left_mag[7:0];
         POS_LEFT_HI:  cur_byte = frame_ff.left_mag[15:8];
         POS_RIGHT_LO: cur_byte = frame_ff.right_mag[7:0];
         POS_RIGHT_HI: cur_byte = frame_ff.right_mag[15:8];
         POS_CTRL:     cur_byte = frame_ff.ctrl;
         POS_CRC_LO:   cur_byte = crc_ff[7:0];
         POS_CRC_HI:   cur_byte = crc_ff[15:8];
         default:      cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      frame_in = frame_ff;
      crc_in   = crc_ff;
      if (load) begin
         busy_in  = 1'b1;
         pos_in   = POS_SYNC;
         frame_in = load_frame;
         crc_in   = CrcSeed;
      end else if (out_take) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            pos_in = byte_pos_type'(pos_ff + 4'd1);
         end
         case (pos_ff) inside
            POS_ID, POS_LEFT_LO, POS_LEFT_HI, POS_RIGHT_LO, POS_RIGHT_HI, POS_CTRL:
               crc_in = crc_byte(crc_ff, cur_byte);
            default:
               crc_in = crc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= POS_SYNC;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      crc_ff   <= crc_in;
   end

   assign rsp_valid      = busy_ff;
   assign rsp_frame_byte = cur_byte;
   assign rsp_last_byte  = at_last;

   `DCFE_ASSERT_NXT(a_pos_advance, clock, reset, out_take && !at_last, pos_ff == byte_pos_type'($past(pos_ff) + 4'd1))
   `DCFE_ASSERT_NXT(a_drain, clock, reset, out_take && at_last && !load_valid, !busy_ff)
   `DCFE_ASSERT_NXT(a_load_start, clock, reset, load, busy_ff && pos_ff == POS_SYNC && crc_ff == CrcSeed)
   `DCFE_ASSERT_NXT(a_stall_hold, clock, reset, busy_ff && rsp_stall, $stable(crc_ff) && $stable(pos_ff))
   `DCFE_ASSERT_IMP(a_load_gap, clock, reset, busy_ff && !at_last, !load_ready)

endmodule

/* rtl/drive_command_frame_encoder.sv */
// Top level of the drive command frame encoder: input holding register and byte serializer.
// Depends on dcfe_pkg, dcfe_input_stage and dcfe_serializer.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_left/right_speed_order, req_speed_control
//   rsp     | out       | rsp_valid, rsp_stall, rsp_frame_byte, rsp_last_byte
//
// Each item yields nine bytes, one per cycle while rsp_stall is low, and the next item
// loads as the last byte leaves, so frames follow back to back; the result port is byte wide.
// The CRC is folded in one byte per cycle as bytes 1..6 leave, and holds while rsp_stall is high.
// One further item is held in the input register while a frame is sent.
// Synchronous active high reset clears both valid flags.
// A stalled result holds its byte; the input stalls only when the holding register is full.
module drive_command_frame_encoder
   import dcfe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_left_speed_order,
   input  logic signed [15:0] req_right_speed_order,
   input  logic               req_speed_control,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_frame_byte,
   output logic               rsp_last_byte
);

   logic             load_ready;
   logic             hold_valid;
   frame_fields_type hold_frame;

   dcfe_input_stage u_input_stage (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_left_speed_order  (req_left_speed_order),
      .req_right_speed_order (req_right_speed_order),
      .req_speed_control     (req_speed_control),
      .load_ready            (load_ready),
      .hold_valid            (hold_valid),
      .hold_frame            (hold_frame)
   );

   dcfe_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .load_valid     (hold_valid),
      .load_frame     (hold_frame),
      .load_ready     (load_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule
